FILE: sv/pwf_pkg.sv
`default_nettype none

package pwf_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_SPATIAL_FREQ   = 3'd0;
    localparam logic [2:0] REG_TEMPORAL_FREQ  = 3'd1;
    localparam logic [2:0] REG_TURBULENCE_AMP = 3'd2;
    localparam logic [2:0] REG_MEAN_WIND_X    = 3'd3;
    localparam logic [2:0] REG_MEAN_WIND_Y    = 3'd4;
    localparam logic [2:0] REG_MEAN_WIND_Z    = 3'd5;

    // Angles in Q30 radians, used to build the sine table.
    localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Phase multipliers as turn fractions per radian, Q32.
    localparam int NUM_PHASE = 5;
    localparam logic [29:0] MUL_1_00 = 30'd683565276;
    localparam logic [29:0] MUL_0_83 = 30'd567359179;
    localparam logic [29:0] MUL_0_91 = 30'd622044401;
    localparam logic [29:0] MUL_1_07 = 30'd731414845;
    localparam logic [29:0] MUL_0_89 = 30'd608373095;

    // Indexes of the phase terms.
    localparam int PH_100 = 0;
    localparam int PH_083 = 1;
    localparam int PH_091 = 2;
    localparam int PH_107 = 3;
    localparam int PH_089 = 4;

    // Fixed angle offsets in turns, Q0.32.
    localparam logic [31:0] OFF_0_71 = 32'd485331346;
    localparam logic [31:0] OFF_1_37 = 32'd936484428;
    localparam logic [31:0] OFF_2_11 = 32'd1442322731;
    localparam logic [31:0] OFF_0_29 = 32'd198233930;
    localparam logic [31:0] OFF_1_63 = 32'd1114211399;
    localparam logic [31:0] OFF_2_73 = 32'd1866133202;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    typedef logic signed [31:0] sine_t;

endpackage

`default_nettype wire

FILE: sv/pwf_sine_rom.sv
`default_nettype none

module pwf_sine_rom #(
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    output pwf_pkg::sine_t                data
);
    import pwf_pkg::*;

    typedef sine_t rom_t [DEPTH];
    typedef longint unsigned div_t [8];

    localparam div_t TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72,
                                    64'd110, 64'd156, 64'd210, 64'd272};

    // One table entry: Q30 angle, quadrant fold, then a nine-term series
    // whose steps truncate.
    function automatic sine_t sine_entry(longint unsigned i);
        longint unsigned a;
        longint unsigned term;
        longint          sum;
        logic            neg;
        a   = (i * TWO_PI_Q30 + DEPTH / 2) / DEPTH;
        neg = 1'b0;
        if (a >= PI_Q30)
        begin
            a   = a - PI_Q30;
            neg = 1'b1;
        end
        if (a > HALF_PI_Q30)
            a = PI_Q30 - a;
        sum  = longint'(a);
        term = a;
        for (int k = 0; k < 8; k++)
        begin
            term = (term * a) >> 30;
            term = (term * a) >> 30;
            term = term / TAYLOR_DIV[k];
            if (k % 2 == 0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > 64'sd1073741824)
            sum = 64'sd1073741824;
        if (neg)
            sum = -sum;
        return sine_t'(sum);
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < DEPTH; i++)
            r[i] = sine_entry(longint'(i));
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    sine_t data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= ROM[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

FILE: sv/procedural_wind_field.sv
// Procedural wind field: turbulent, divergence-free wind plus a mean wind.
// Throughput: one word per cycle while the output is not stalled; the eleven
// register stages and the six sine table reads each advance together and
// hold on a stall.
// Reset (rst_n low, asynchronous) clears all valid bits and sets every
// configuration register to zero; the sine tables are constant and need none.
`default_nettype none

module procedural_wind_field #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int ANGLE_FRAC_BITS  = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    // Configuration write channel.
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [31:0]  cfg_data,

    // Input stream.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // From bit 0: pos_x[31:0], pos_y[31:0], pos_z[31:0], sim_time[47:0].
    input  wire logic [143:0] s_tdata,

    // Output stream.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // From bit 0: wind_x[31:0], wind_y[31:0], wind_z[31:0].
    output logic [95:0]       m_tdata
);
    import pwf_pkg::*;

    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int SCALE_W = ANGLE_FRAC_BITS + $clog2(SINE_TABLE_DEPTH + 1);
    localparam logic [SCALE_W-1:0] HALF_LSB   = SCALE_W'(1) << (ANGLE_FRAC_BITS - 1);
    localparam logic [SCALE_W-1:0] DEPTH_W    = SCALE_W'(SINE_TABLE_DEPTH);
    localparam logic signed [65:0] ROUND_HALF = 66'sd1 <<< 30;
    localparam logic signed [35:0] SAT_MAX    = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN    = -36'sd2147483648;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; bits beyond a
    // register's width are dropped and unknown indexes are ignored.
    // ------------------------------------------------------------------
    logic [23:0]        spatial_freq_reg;
    logic [23:0]        temporal_freq_reg;
    logic [31:0]        turbulence_amp_reg;
    logic signed [31:0] mean_reg [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spatial_freq_reg   <= '0;
            temporal_freq_reg  <= '0;
            turbulence_amp_reg <= '0;
            mean_reg[0]        <= '0;
            mean_reg[1]        <= '0;
            mean_reg[2]        <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                REG_SPATIAL_FREQ:   spatial_freq_reg   <= cfg_data[23:0];
                REG_TEMPORAL_FREQ:  temporal_freq_reg  <= cfg_data[23:0];
                REG_TURBULENCE_AMP: turbulence_amp_reg <= cfg_data;
                REG_MEAN_WIND_X:    mean_reg[0]        <= cfg_data;
                REG_MEAN_WIND_Y:    mean_reg[1]        <= cfg_data;
                REG_MEAN_WIND_Z:    mean_reg[2]        <= cfg_data;
                default: ;
            endcase
        end
    end

    // The frequencies are folded with their turn-per-radian multipliers once,
    // into coefficient registers that are reloaded on the edge after a write. The
    // input word spends two stages in flight before it meets them, so a word
    // accepted on the very edge of a write still sees the new value.
    logic [53:0] kc_reg;
    logic [53:0] g_reg [NUM_PHASE];
    logic [29:0] ph_mul [NUM_PHASE];

    assign ph_mul[PH_100] = MUL_1_00;
    assign ph_mul[PH_083] = MUL_0_83;
    assign ph_mul[PH_091] = MUL_0_91;
    assign ph_mul[PH_107] = MUL_1_07;
    assign ph_mul[PH_089] = MUL_0_89;

    always_ff @(posedge clk)
    begin
        kc_reg <= 54'(spatial_freq_reg) * 54'(MUL_1_00);
        for (int j = 0; j < NUM_PHASE; j++)
            g_reg[j] <= 54'(temporal_freq_reg) * 54'(ph_mul[j]);
    end

    // ------------------------------------------------------------------
    // Pipeline control. All stages advance together unless the output word
    // is stalled; empty output stage lets the line move regardless.
    // ------------------------------------------------------------------
    logic        en;
    logic [11:1] v_reg;

    assign en       = !v_reg[11] || m_tready;
    assign s_tready = en;
    assign m_tvalid = v_reg[11];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[10:1], s_tvalid};
    end

    // Stage 1 and 2: input capture and alignment with the coefficients.
    logic signed [31:0] s1_pos_reg [3];
    logic [47:0]        s1_time_reg;
    logic signed [31:0] s2_pos_reg [3];
    logic [47:0]        s2_time_reg;

    // Stage 3: partial products. The time is split in two 24-bit halves and
    // each coefficient in two 27-bit halves; only bits below 2^64 matter.
    logic [50:0]        s3_pp_reg [NUM_PHASE][4];
    logic signed [59:0] s3_sp_reg [3][2];

    // Stage 4: pair sums, and the spatial terms finished.
    logic [63:0]        s4_lo_reg [NUM_PHASE];
    logic [63:0]        s4_hi_reg [NUM_PHASE];
    logic [31:0]        s4_k_reg [3];

    // Stage 5: phase terms finished.
    logic [31:0]        s5_ph_reg [NUM_PHASE];
    logic [31:0]        s5_k_reg [3];

    // Stage 6: the six angles, cosine angles already advanced a quarter turn.
    // Order: x cos, x sin, y cos, y sin, z cos, z sin.
    logic [31:0]        s6_ang_reg [6];

    // Stage 7: table indexes. Stage 8 is the table read.
    logic [IDX_W-1:0]   s7_idx_reg [6];
    sine_t              s8_sin [6];

    // Stages 9 to 11: difference, amplitude product, round and saturate.
    logic signed [32:0] s9_diff_reg [3];
    logic signed [65:0] s10_prod_reg [3];
    logic [95:0]        s11_data_reg;

    logic [63:0]        sp_sum [3];
    logic [63:0]        ph_sum [NUM_PHASE];
    logic [ANGLE_FRAC_BITS-1:0] ang [6];
    logic [SCALE_W-1:0] scaled [6];
    logic [SCALE_W-ANGLE_FRAC_BITS-1:0] idx_wide [6];
    logic signed [65:0] rounded [3];
    logic signed [35:0] wind [3];
    logic [31:0]        wind_sat [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sp_sum[i] = 64'(s3_sp_reg[i][0]) + (64'(s3_sp_reg[i][1]) << 27);
        for (int j = 0; j < NUM_PHASE; j++)
            ph_sum[j] = s4_lo_reg[j] + s4_hi_reg[j];
        for (int a = 0; a < 6; a++)
        begin
            ang[a]      = s6_ang_reg[a][31 -: ANGLE_FRAC_BITS];
            scaled[a]   = SCALE_W'(ang[a]) * DEPTH_W + HALF_LSB;
            idx_wide[a] = scaled[a][SCALE_W-1:ANGLE_FRAC_BITS];
        end
        for (int c = 0; c < 3; c++)
        begin
            rounded[c] = (s10_prod_reg[c] + ROUND_HALF) >>> 31;
            wind[c]    = 36'(mean_reg[c]) + 36'(rounded[c]);
            if (wind[c] > SAT_MAX)
                wind_sat[c] = SAT_MAX[31:0];
            else if (wind[c] < SAT_MIN)
                wind_sat[c] = SAT_MIN[31:0];
            else
                wind_sat[c] = wind[c][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pos_reg[0] <= s_tdata[31:0];
            s1_pos_reg[1] <= s_tdata[63:32];
            s1_pos_reg[2] <= s_tdata[95:64];
            s1_time_reg   <= s_tdata[143:96];

            s2_pos_reg  <= s1_pos_reg;
            s2_time_reg <= s1_time_reg;

            for (int j = 0; j < NUM_PHASE; j++)
            begin
                s3_pp_reg[j][0] <= 51'(s2_time_reg[23:0])  * 51'(g_reg[j][26:0]);
                s3_pp_reg[j][1] <= 51'(s2_time_reg[23:0])  * 51'(g_reg[j][53:27]);
                s3_pp_reg[j][2] <= 51'(s2_time_reg[47:24]) * 51'(g_reg[j][26:0]);
                s3_pp_reg[j][3] <= 51'(s2_time_reg[47:24]) * 51'(g_reg[j][53:27]);
            end
            for (int i = 0; i < 3; i++)
            begin
                s3_sp_reg[i][0] <= 60'(s2_pos_reg[i]) * $signed({33'd0, kc_reg[26:0]});
                s3_sp_reg[i][1] <= 60'(s2_pos_reg[i]) * $signed({33'd0, kc_reg[53:27]});
            end

            for (int j = 0; j < NUM_PHASE; j++)
            begin
                s4_lo_reg[j] <= 64'(s3_pp_reg[j][0]) + (64'(s3_pp_reg[j][1]) << 27);
                s4_hi_reg[j] <= (64'(s3_pp_reg[j][2]) << 24) + (64'(s3_pp_reg[j][3]) << 51);
            end
            for (int i = 0; i < 3; i++)
                s4_k_reg[i] <= sp_sum[i][63:32];

            for (int j = 0; j < NUM_PHASE; j++)
                s5_ph_reg[j] <= ph_sum[j][63:32];
            s5_k_reg <= s4_k_reg;

            s6_ang_reg[0] <= s5_k_reg[1] + s5_ph_reg[PH_100] + OFF_0_71 + QUARTER_TURN;
            s6_ang_reg[1] <= s5_k_reg[2] - s5_ph_reg[PH_083] + OFF_1_37;
            s6_ang_reg[2] <= s5_k_reg[2] + s5_ph_reg[PH_091] + OFF_2_11 + QUARTER_TURN;
            s6_ang_reg[3] <= s5_k_reg[0] - s5_ph_reg[PH_100] + OFF_0_29;
            s6_ang_reg[4] <= s5_k_reg[0] + s5_ph_reg[PH_107] + OFF_1_63 + QUARTER_TURN;
            s6_ang_reg[5] <= s5_k_reg[1] - s5_ph_reg[PH_089] + OFF_2_73;

            // Rounding can land exactly on the table length; that is angle 0.
            for (int a = 0; a < 6; a++)
            begin
                if (idx_wide[a] >= ($bits(idx_wide[a]))'(SINE_TABLE_DEPTH))
                    s7_idx_reg[a] <= '0;
                else
                    s7_idx_reg[a] <= idx_wide[a][IDX_W-1:0];
            end

            for (int c = 0; c < 3; c++)
            begin
                s9_diff_reg[c]  <= 33'(s8_sin[2*c]) - 33'(s8_sin[2*c+1]);
                s10_prod_reg[c] <= $signed({34'd0, turbulence_amp_reg}) * 66'(s9_diff_reg[c]);
            end

            s11_data_reg <= {wind_sat[2], wind_sat[1], wind_sat[0]};
        end
    end

    // One table copy per angle, each read once per cycle while the pipeline is not stalled.
    for (genvar r = 0; r < 6; r++)
    begin : g_rom
        pwf_sine_rom #(
            .DEPTH (SINE_TABLE_DEPTH)
        ) u_rom (
            .clk  (clk),
            .en   (en),
            .addr (s7_idx_reg[r]),
            .data (s8_sin[r])
        );
    end

    assign m_tdata = s11_data_reg;

endmodule

`default_nettype wire
